// ===== hdl/igh_pkg.sv =====
// ============================================================================
// igh_pkg
// Types and fixed constants shared by the integral gradient histogram block.
// ============================================================================
`default_nettype none

package igh_pkg;

    localparam int VALUE_W     = 52;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROI_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BINS_IN_USE = 2'd1;

    localparam logic [10:0] ROI_WIDTH_RESET   = 11'd640;
    localparam logic [4:0]  BINS_IN_USE_RESET = 5'd8;

    typedef struct packed {
        logic        command;
        logic [3:0]  bin_index;
        logic [8:0]  angle;
        logic [15:0] weight;
        logic [15:0] magnitude;
        logic        frame_start;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_bin;
        logic [VALUE_W-1:0] integral_value;
        logic               last_bin;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/integral_gradient_histogram.sv =====
// ============================================================================
// integral_gradient_histogram
// Streaming integral histogram of oriented gradients over a region of interest.
// ============================================================================
// Usage: pixel and weight-load transactions arrive on the s_ channel. A load
// transaction writes one weight table entry if its bin and angle are in range
// and yields nothing. A pixel transaction yields one transaction per bin in
// use on the m_ channel, in bin order, with last_bin set on the final one.
// Registers are to be written on the cfg_ channel only while the block is idle;
// the block itself does not enforce this, and cfg_ready is always high. The
// first result of a pixel passes from the sequencer through the memory read
// and multiply registers into the output register. The sequencer steps one bin
// per cycle unless stalled; it takes input only when idle or on its last bin.
// The datapath is a four-register pipeline: sequencer, memory read,
// multiply, and the integral add with saturation into the output register.
// Reset clears the pipeline, the column position and the registers to their
// defaults; the weight and line memories hold no defined contents until
// written. When the receiver stalls, the whole pipeline holds and s_ready
// falls, so no transaction is lost or repeated.
// ============================================================================
`default_nettype none

module integral_gradient_histogram #(
    parameter int NUM_BINS      = 8,
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int ANGLE_ENTRIES = 315
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire igh_pkg::in_item_t                  s_data,
    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      igh_pkg::out_item_t                 m_data,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [igh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [igh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int AW = $clog2(ANGLE_ENTRIES);
    localparam int VW = igh_pkg::VALUE_W;

    localparam logic [9:0]  ANG_MAX  = 10'(ANGLE_ENTRIES - 1);
    localparam logic [12:0] WIDTH_MX = 13'(MAX_ROW_WIDTH);
    localparam logic [4:0]  BINS_MX  = 5'(NUM_BINS);

    logic [15:0]   weight_mem [NUM_BINS][ANGLE_ENTRIES];
    logic [VW-1:0] line_mem   [MAX_ROW_WIDTH][NUM_BINS];
    logic [VW-1:0] row_sum_reg    [NUM_BINS];
    logic [VW-1:0] above_left_reg [NUM_BINS];
    logic [NUM_BINS-1:0] row_live_reg;
    logic [NUM_BINS-1:0] row_live_next;

    logic [10:0]   roi_width_reg;
    logic [4:0]    bins_in_use_reg;
    logic [CW-1:0] col_reg;
    logic          first_row_reg;

    logic          s0_valid_reg;
    logic [15:0]   s0_mag_reg;
    logic [AW-1:0] s0_ang_reg;
    logic [CW-1:0] s0_col_reg;
    logic          s0_fr_reg;
    logic [BW-1:0] s0_bin_reg;
    logic [BW-1:0] s0_last_reg;

    logic          s1_valid_reg;
    logic [15:0]   s1_mag_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_fr_reg;
    logic [BW-1:0] s1_bin_reg;
    logic          s1_last_reg;
    logic          s1_fwd1_reg;
    logic          s1_fwd2_reg;
    logic [VW-1:0] s1_byp_reg;
    logic [15:0]   s1_weight_reg;
    logic [VW-1:0] s1_line_reg;

    logic          s2_valid_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_fr_reg;
    logic [BW-1:0] s2_bin_reg;
    logic          s2_last_reg;
    logic [31:0]   s2_prod_reg;
    logic [VW-1:0] s2_up_reg;

    logic               out_valid_reg;
    igh_pkg::out_item_t out_data_reg;

    logic          en;
    logic          s_accept;
    logic          pix_accept;
    logic          load_accept;
    logic          s0_done;
    logic [9:0]    ang_ext;
    logic [9:0]    ang_clamp;
    logic          load_ok;
    logic [12:0]   eff_width;
    logic [4:0]    eff_bins;
    logic [CW-1:0] col_a;
    logic          fr_a;
    logic [CW-1:0] col_b;
    logic          fr_b;
    logic [12:0]   col_inc;
    logic [CW-1:0] col_next;
    logic          first_row_next;
    logic          fwd1;
    logic          fwd2;
    logic [31:0]   s1_prod;
    logic [VW-1:0] s1_up;
    logic [VW-1:0] s1_up_fwd;
    logic [VW-1:0] left_val;
    logic [VW-1:0] ul_val;
    logic [VW-1:0] up_eff;
    logic [VW+1:0] pos_sum;
    logic [VW+1:0] diff;
    logic [VW-1:0] v_comb;

    assign en          = !out_valid_reg || m_ready;
    assign s0_done     = !s0_valid_reg || (s0_bin_reg == s0_last_reg);
    assign s_ready     = en && s0_done;
    assign s_accept    = s_valid && s_ready;
    assign pix_accept  = s_accept && (s_data.command == igh_pkg::CMD_PIXEL);
    assign load_accept = s_accept && (s_data.command == igh_pkg::CMD_LOAD);
    assign cfg_ready   = 1'b1;
    assign m_valid     = out_valid_reg;
    assign m_data      = out_data_reg;

    always_comb begin
        ang_ext   = {1'b0, s_data.angle};
        ang_clamp = (ang_ext > ANG_MAX) ? ANG_MAX : ang_ext;
        load_ok   = (ang_ext <= ANG_MAX) && ({1'b0, s_data.bin_index} < BINS_MX);

        if (roi_width_reg == 11'd0) begin
            eff_width = 13'd1;
        end else if (13'(roi_width_reg) > WIDTH_MX) begin
            eff_width = WIDTH_MX;
        end else begin
            eff_width = 13'(roi_width_reg);
        end

        if (bins_in_use_reg == 5'd0) begin
            eff_bins = 5'd1;
        end else if (bins_in_use_reg > BINS_MX) begin
            eff_bins = BINS_MX;
        end else begin
            eff_bins = bins_in_use_reg;
        end

        col_a = s_data.frame_start ? '0 : col_reg;
        fr_a  = s_data.frame_start ? 1'b1 : first_row_reg;
        if (13'(col_a) >= eff_width) begin
            col_b = '0;
            fr_b  = 1'b0;
        end else begin
            col_b = col_a;
            fr_b  = fr_a;
        end
        col_inc = 13'(col_b) + 13'd1;
        if (col_inc >= eff_width) begin
            col_next       = '0;
            first_row_next = 1'b0;
        end else begin
            col_next       = col_inc[CW-1:0];
            first_row_next = fr_b;
        end
    end

    assign fwd1 = s1_valid_reg && (s1_col_reg == s0_col_reg) && (s1_bin_reg == s0_bin_reg);
    assign fwd2 = s2_valid_reg && (s2_col_reg == s0_col_reg) && (s2_bin_reg == s0_bin_reg);

    assign s1_prod   = 32'(s1_mag_reg) * 32'(s1_weight_reg);
    assign s1_up     = s1_fwd2_reg ? s1_byp_reg : s1_line_reg;
    assign s1_up_fwd = s1_fwd1_reg ? v_comb : s1_up;

    always_comb begin
        left_val = ((s2_col_reg == '0) || !row_live_reg[s2_bin_reg]) ? '0
                 : row_sum_reg[s2_bin_reg];
        ul_val   = ((s2_col_reg == '0) || s2_fr_reg || !row_live_reg[s2_bin_reg]) ? '0
                 : above_left_reg[s2_bin_reg];
        up_eff   = s2_fr_reg ? '0 : s2_up_reg;
        pos_sum  = (VW+2)'(s2_prod_reg) + (VW+2)'(left_val) + (VW+2)'(up_eff);
        diff     = pos_sum - (VW+2)'(ul_val);
        if (pos_sum < (VW+2)'(ul_val)) begin
            v_comb = '0;
        end else if (diff > (VW+2)'(igh_pkg::VALUE_MAX)) begin
            v_comb = igh_pkg::VALUE_MAX;
        end else begin
            v_comb = diff[VW-1:0];
        end
    end

    // The first bin of a pixel in column zero opens a new row, so the row sums of
    // every other bin count as cleared until that bin is computed again.
    always_comb begin
        row_live_next = row_live_reg;
        if ((s2_col_reg == '0) && (s2_bin_reg == '0)) begin
            row_live_next = '0;
        end
        row_live_next[s2_bin_reg] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_width_reg   <= igh_pkg::ROI_WIDTH_RESET;
            bins_in_use_reg <= igh_pkg::BINS_IN_USE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                igh_pkg::REG_ROI_WIDTH:   roi_width_reg   <= cfg_data[10:0];
                igh_pkg::REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end else if (pix_accept) begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            if (pix_accept) begin
                s0_valid_reg <= 1'b1;
            end else if (s0_done) begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            s0_mag_reg  <= s_data.magnitude;
            s0_ang_reg  <= ang_clamp[AW-1:0];
            s0_col_reg  <= col_b;
            s0_fr_reg   <= fr_b;
            s0_bin_reg  <= '0;
            s0_last_reg <= BW'(eff_bins - 5'd1);
        end else if (en && s0_valid_reg && !s0_done) begin
            s0_bin_reg <= s0_bin_reg + BW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_accept && load_ok) begin
            weight_mem[s_data.bin_index[BW-1:0]][ang_clamp[AW-1:0]] <= s_data.weight;
        end
        if (en) begin
            s1_weight_reg <= weight_mem[s0_bin_reg][s0_ang_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s2_valid_reg) begin
            line_mem[s2_col_reg][s2_bin_reg] <= v_comb;
        end
        if (en) begin
            s1_line_reg <= line_mem[s0_col_reg][s0_bin_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg  <= s0_mag_reg;
            s1_col_reg  <= s0_col_reg;
            s1_fr_reg   <= s0_fr_reg;
            s1_bin_reg  <= s0_bin_reg;
            s1_last_reg <= (s0_bin_reg == s0_last_reg);
            s1_fwd1_reg <= fwd1;
            s1_fwd2_reg <= fwd2;
            s1_byp_reg  <= v_comb;

            s2_col_reg  <= s1_col_reg;
            s2_fr_reg   <= s1_fr_reg;
            s2_bin_reg  <= s1_bin_reg;
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= s1_prod;
            s2_up_reg   <= s1_up_fwd;

            out_data_reg.out_bin        <= 4'(s2_bin_reg);
            out_data_reg.integral_value <= v_comb;
            out_data_reg.last_bin       <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s2_valid_reg) begin
            row_sum_reg[s2_bin_reg]    <= v_comb;
            above_left_reg[s2_bin_reg] <= up_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_live_reg <= '0;
        end else if (en && s2_valid_reg) begin
            row_live_reg <= row_live_next;
        end
    end

endmodule

`default_nettype wire
